FILE: hdl/es2utc_pkg.sv
package es2utc_pkg;

   localparam int CNT_WIDTH = 2;

   // The constant divider runs three steps: reciprocal estimate, remainder,
   // and one correction.
   localparam logic [CNT_WIDTH-1:0] DIV_STEPS     = 2'd3;
   localparam logic [CNT_WIDTH-1:0] DIV_PHASE_MUL = 2'd3;
   localparam logic [CNT_WIDTH-1:0] DIV_PHASE_REM = 2'd2;
   localparam logic [CNT_WIDTH-1:0] DIV_PHASE_FIX = 2'd1;

   // 86400 = 128 * 675, 3600 = 16 * 225 and 60 = 4 * 15. The low bits of each
   // dividend bypass the divider and rejoin the remainder afterwards. Each
   // reciprocal is floor(2^32 / divisor), so the estimate is at most one low.
   localparam logic [9:0]  DAY_DIVISOR  = 10'd675;
   localparam logic [29:0] DAY_RECIP    = 30'd6362914;
   localparam logic [9:0]  WEEK_DIVISOR = 10'd7;
   localparam logic [29:0] WEEK_RECIP   = 30'd613566756;
   localparam logic [9:0]  HOUR_DIVISOR = 10'd225;
   localparam logic [29:0] HOUR_RECIP   = 30'd19088743;
   localparam logic [9:0]  MIN_DIVISOR  = 10'd15;
   localparam logic [29:0] MIN_RECIP    = 30'd286331153;

   // 1970-01-01 was a Thursday, four days after a Sunday.
   localparam logic [24:0]          EPOCH_WEEKDAY_OFS = 25'd4;
   localparam logic [7:0]           FIRST_YEAR_OFS    = 8'd70;
   localparam logic [7:0]           YEAR_OFS_1900     = 8'd0;
   localparam logic [7:0]           YEAR_OFS_2100     = 8'd200;
   localparam logic [8:0]           DAYS_COMMON_YEAR  = 9'd365;
   localparam logic [8:0]           DAYS_LEAP_YEAR    = 9'd366;
   localparam logic [8:0]           LAST_DAY_OF_FEB   = 9'd58;
   localparam logic [8:0]           LEAP_DAY_YDAY     = 9'd59;
   localparam logic [3:0]           LAST_MONTH        = 4'd11;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_DAY,
      S_START_WEEK,
      S_DIV_WEEK,
      S_START_HOUR,
      S_DIV_HOUR,
      S_START_MIN,
      S_DIV_MIN,
      S_YEAR_INIT,
      S_YEAR,
      S_MONTH_INIT,
      S_MONTH,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD_DAY,
      OP_DIV_STEP,
      OP_START_WEEK,
      OP_START_HOUR,
      OP_START_MIN,
      OP_YEAR_INIT,
      OP_YEAR_STEP,
      OP_MONTH_INIT,
      OP_MONTH_STEP,
      OP_OUT_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic year_fits;
      logic month_found;
   } status_type;

   typedef struct packed {
      logic [5:0] second_of_minute;
      logic [5:0] minute_of_hour;
      logic [4:0] hour_of_day;
      logic [2:0] weekday_number;
      logic [7:0] years_since_1900;
      logic [8:0] day_of_year;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
   } result_type;

   // Gregorian rule over the years that an 8-bit offset from 1900 can reach:
   // 1900 and 2100 are the century years that are not leap years.
   function automatic logic is_leap(input logic [7:0] year_ofs);
      is_leap = (year_ofs[1:0] == 2'b00) && (year_ofs != YEAR_OFS_1900) &&
                (year_ofs != YEAR_OFS_2100);
   endfunction

   function automatic logic [8:0] year_length(input logic [7:0] year_ofs);
      year_length = is_leap(year_ofs) ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
   endfunction

   // First day of each month in a common year, counted from zero.
   function automatic logic [8:0] month_start(input logic [3:0] month);
      case (month)
         4'd0:    month_start = 9'd0;
         4'd1:    month_start = 9'd31;
         4'd2:    month_start = 9'd59;
         4'd3:    month_start = 9'd90;
         4'd4:    month_start = 9'd120;
         4'd5:    month_start = 9'd151;
         4'd6:    month_start = 9'd181;
         4'd7:    month_start = 9'd212;
         4'd8:    month_start = 9'd243;
         4'd9:    month_start = 9'd273;
         4'd10:   month_start = 9'd304;
         4'd11:   month_start = 9'd334;
         default: month_start = 9'd0;
      endcase
   endfunction

endpackage

FILE: hdl/es2utc_if.sv
interface es2utc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2utc_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] second_of_minute;
   logic [5:0] minute_of_hour;
   logic [4:0] hour_of_day;
   logic [2:0] weekday_number;
   logic [7:0] years_since_1900;
   logic [8:0] day_of_year;
   logic [3:0] month_index;
   logic [4:0] day_of_month;

   modport source (output valid, output second_of_minute, output minute_of_hour,
                   output hour_of_day, output weekday_number, output years_since_1900,
                   output day_of_year, output month_index, output day_of_month,
                   input ready);
   modport sink   (input valid, input second_of_minute, input minute_of_hour,
                   input hour_of_day, input weekday_number, input years_since_1900,
                   input day_of_year, input month_index, input day_of_month,
                   output ready);
endinterface

FILE: hdl/es2utc_datapath.sv
module es2utc_datapath (
   input  logic                   clock,
   input  es2utc_pkg::cmd_type    cmd,
   input  logic [31:0]            epoch_seconds,
   output es2utc_pkg::status_type status,
   output es2utc_pkg::result_type result
);

   logic [24:0] div_x_ff, div_x_in;
   logic [9:0]  div_d_ff, div_d_in;
   logic [29:0] div_m_ff, div_m_in;
   logic [15:0] div_q_ff, div_q_in;
   logic [10:0] div_r_ff, div_r_in;
   logic [1:0]  div_cnt_ff, div_cnt_in;
   logic [6:0]  low_ff, low_in;
   logic [16:0] sod_ff, sod_in;
   logic [15:0] days_ff, days_in;
   logic [7:0]  year_ff, year_in;
   logic [8:0]  work_ff, work_in;
   logic [1:0]  mday_base_ff, mday_base_in;
   logic [3:0]  mon_ff, mon_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [2:0]  wday_ff, wday_in;
   es2utc_pkg::result_type result_ff, result_in;

   logic [47:0] div_prod;
   logic [24:0] div_back;
   logic [24:0] div_diff;
   logic        div_over;
   logic [8:0]  year_len;
   logic [8:0]  cur_month_start;
   logic [8:0]  mday_wide;

   // The quotient estimate is the top of dividend times reciprocal; the
   // remainder left by it is below twice the divisor.
   assign div_prod = 48'(div_x_ff) * 48'(div_m_ff);
   assign div_back = 25'(div_q_ff) * 25'(div_d_ff);
   assign div_diff = div_x_ff - div_back;
   assign div_over = (div_r_ff >= {1'b0, div_d_ff});

   assign year_len        = es2utc_pkg::year_length(year_ff);
   assign cur_month_start = es2utc_pkg::month_start(mon_ff);
   assign mday_wide       = {7'd0, mday_base_ff} + work_ff - cur_month_start;

   assign status.div_last    = (div_cnt_ff == es2utc_pkg::DIV_PHASE_FIX);
   assign status.year_fits   = (days_ff < {7'd0, year_len});
   assign status.month_found = (mon_ff == 4'd0) || (cur_month_start <= work_ff);

   assign result = result_ff;

   always_comb begin
      div_x_in     = div_x_ff;
      div_d_in     = div_d_ff;
      div_m_in     = div_m_ff;
      div_q_in     = div_q_ff;
      div_r_in     = div_r_ff;
      div_cnt_in   = div_cnt_ff;
      low_in       = low_ff;
      sod_in       = sod_ff;
      days_in      = days_ff;
      year_in      = year_ff;
      work_in      = work_ff;
      mday_base_in = mday_base_ff;
      mon_in       = mon_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      wday_in      = wday_ff;
      result_in    = result_ff;
      case (cmd.op)
         es2utc_pkg::OP_LOAD_DAY: begin
            div_x_in   = epoch_seconds[31:7];
            low_in     = epoch_seconds[6:0];
            div_d_in   = es2utc_pkg::DAY_DIVISOR;
            div_m_in   = es2utc_pkg::DAY_RECIP;
            div_cnt_in = es2utc_pkg::DIV_STEPS;
         end
         es2utc_pkg::OP_DIV_STEP: begin
            case (div_cnt_ff)
               es2utc_pkg::DIV_PHASE_MUL: begin
                  div_q_in = div_prod[47:32];
               end
               es2utc_pkg::DIV_PHASE_REM: begin
                  div_r_in = div_diff[10:0];
               end
               es2utc_pkg::DIV_PHASE_FIX: begin
                  if (div_over) begin
                     div_r_in = div_r_ff - {1'b0, div_d_ff};
                     div_q_in = div_q_ff + 16'd1;
                  end
               end
               default: begin
               end
            endcase
            div_cnt_in = div_cnt_ff - 2'd1;
         end
         es2utc_pkg::OP_START_WEEK: begin
            // The day count fits in 16 bits for any 32-bit input.
            days_in    = div_q_ff;
            sod_in     = {div_r_ff[9:0], low_ff};
            div_x_in   = {9'd0, div_q_ff} + es2utc_pkg::EPOCH_WEEKDAY_OFS;
            div_d_in   = es2utc_pkg::WEEK_DIVISOR;
            div_m_in   = es2utc_pkg::WEEK_RECIP;
            div_cnt_in = es2utc_pkg::DIV_STEPS;
         end
         es2utc_pkg::OP_START_HOUR: begin
            wday_in    = div_r_ff[2:0] + 3'd1;
            div_x_in   = {12'd0, sod_ff[16:4]};
            low_in     = {3'd0, sod_ff[3:0]};
            div_d_in   = es2utc_pkg::HOUR_DIVISOR;
            div_m_in   = es2utc_pkg::HOUR_RECIP;
            div_cnt_in = es2utc_pkg::DIV_STEPS;
         end
         es2utc_pkg::OP_START_MIN: begin
            hour_in    = div_q_ff[4:0];
            // Seconds within the hour, divided by four on the way in.
            div_x_in   = {15'd0, div_r_ff[7:0], low_ff[3:2]};
            low_in     = {5'd0, low_ff[1:0]};
            div_d_in   = es2utc_pkg::MIN_DIVISOR;
            div_m_in   = es2utc_pkg::MIN_RECIP;
            div_cnt_in = es2utc_pkg::DIV_STEPS;
         end
         es2utc_pkg::OP_YEAR_INIT: begin
            min_in  = div_q_ff[5:0];
            sec_in  = {div_r_ff[3:0], low_ff[1:0]};
            year_in = es2utc_pkg::FIRST_YEAR_OFS;
         end
         es2utc_pkg::OP_YEAR_STEP: begin
            if (!status.year_fits) begin
               days_in = days_ff - {7'd0, year_len};
               year_in = year_ff + 8'd1;
            end
         end
         es2utc_pkg::OP_MONTH_INIT: begin
            mon_in = es2utc_pkg::LAST_MONTH;
            // After 28 February of a leap year the table is read one day
            // earlier; the leap day itself lands on February with a day of 29.
            if (es2utc_pkg::is_leap(year_ff) &&
                (days_ff[8:0] > es2utc_pkg::LAST_DAY_OF_FEB)) begin
               work_in      = days_ff[8:0] - 9'd1;
               mday_base_in = (days_ff[8:0] == es2utc_pkg::LEAP_DAY_YDAY) ? 2'd2 : 2'd1;
            end else begin
               work_in      = days_ff[8:0];
               mday_base_in = 2'd1;
            end
         end
         es2utc_pkg::OP_MONTH_STEP: begin
            if (!status.month_found) begin
               mon_in = mon_ff - 4'd1;
            end
         end
         es2utc_pkg::OP_OUT_LOAD: begin
            result_in.second_of_minute = sec_ff;
            result_in.minute_of_hour   = min_ff;
            result_in.hour_of_day      = hour_ff;
            result_in.weekday_number   = wday_ff;
            result_in.years_since_1900 = year_ff;
            result_in.day_of_year      = days_ff[8:0];
            result_in.month_index      = mon_ff;
            result_in.day_of_month     = mday_wide[4:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      div_x_ff     <= div_x_in;
      div_d_ff     <= div_d_in;
      div_m_ff     <= div_m_in;
      div_q_ff     <= div_q_in;
      div_r_ff     <= div_r_in;
      div_cnt_ff   <= div_cnt_in;
      low_ff       <= low_in;
      sod_ff       <= sod_in;
      days_ff      <= days_in;
      year_ff      <= year_in;
      work_ff      <= work_in;
      mday_base_ff <= mday_base_in;
      mon_ff       <= mon_in;
      sec_ff       <= sec_in;
      min_ff       <= min_in;
      hour_ff      <= hour_in;
      wday_ff      <= wday_in;
      result_ff    <= result_in;
   end

endmodule

FILE: hdl/es2utc_ctrl.sv
module es2utc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  es2utc_pkg::status_type status,
   output es2utc_pkg::cmd_type    cmd
);

   es2utc_pkg::state_type state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= es2utc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = es2utc_pkg::OP_IDLE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         es2utc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = es2utc_pkg::OP_LOAD_DAY;
               state_in = es2utc_pkg::S_DIV_DAY;
            end
         end
         es2utc_pkg::S_DIV_DAY: begin
            cmd.op = es2utc_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = es2utc_pkg::S_START_WEEK;
            end
         end
         es2utc_pkg::S_START_WEEK: begin
            cmd.op   = es2utc_pkg::OP_START_WEEK;
            state_in = es2utc_pkg::S_DIV_WEEK;
         end
         es2utc_pkg::S_DIV_WEEK: begin
            cmd.op = es2utc_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = es2utc_pkg::S_START_HOUR;
            end
         end
         es2utc_pkg::S_START_HOUR: begin
            cmd.op   = es2utc_pkg::OP_START_HOUR;
            state_in = es2utc_pkg::S_DIV_HOUR;
         end
         es2utc_pkg::S_DIV_HOUR: begin
            cmd.op = es2utc_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = es2utc_pkg::S_START_MIN;
            end
         end
         es2utc_pkg::S_START_MIN: begin
            cmd.op   = es2utc_pkg::OP_START_MIN;
            state_in = es2utc_pkg::S_DIV_MIN;
         end
         es2utc_pkg::S_DIV_MIN: begin
            cmd.op = es2utc_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = es2utc_pkg::S_YEAR_INIT;
            end
         end
         es2utc_pkg::S_YEAR_INIT: begin
            cmd.op   = es2utc_pkg::OP_YEAR_INIT;
            state_in = es2utc_pkg::S_YEAR;
         end
         es2utc_pkg::S_YEAR: begin
            cmd.op = es2utc_pkg::OP_YEAR_STEP;
            if (status.year_fits) begin
               state_in = es2utc_pkg::S_MONTH_INIT;
            end
         end
         es2utc_pkg::S_MONTH_INIT: begin
            cmd.op   = es2utc_pkg::OP_MONTH_INIT;
            state_in = es2utc_pkg::S_MONTH;
         end
         es2utc_pkg::S_MONTH: begin
            cmd.op = es2utc_pkg::OP_MONTH_STEP;
            if (status.month_found) begin
               state_in = es2utc_pkg::S_OUT;
            end
         end
         es2utc_pkg::S_OUT: begin
            // The result register is reloaded only once its last result has
            // been transferred, or is being transferred in this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = es2utc_pkg::OP_OUT_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = es2utc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = es2utc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/epoch_seconds_to_utc_date.sv
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into a broken-down UTC calendar date and time of day.
// The req channel carries one timestamp per transfer; the rsp channel
// returns exactly one result per timestamp, in order: second, minute, hour,
// weekday (1 is Sunday), year minus 1900, day of year, month and day of month.
// One item is worked at a time. A shared constant divider (reciprocal
// multiply, remainder and one correction, after a setup state per division)
// splits the seconds into days, then finds the weekday, hour and minute.
// Years are then removed one per cycle, and the month is found by a
// downward table search. The next timestamp can be taken in the same cycle
// that the previous result is first shown.
// The result sits in an output register, so a new timestamp is taken while
// the previous result waits; if the receiver still stalls when the next
// result is done, the block holds that result internally until it can load.
// Synchronous reset returns the controller to idle and drops rsp valid.
module epoch_seconds_to_utc_date (
   input logic                clock,
   input logic                reset,
   es2utc_req_if.sink         req_chan,
   es2utc_rsp_if.source       rsp_chan
);

   es2utc_pkg::cmd_type    cmd;
   es2utc_pkg::status_type status;
   es2utc_pkg::result_type result;

   es2utc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   es2utc_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .epoch_seconds (req_chan.epoch_seconds),
      .status        (status),
      .result        (result)
   );

   assign rsp_chan.second_of_minute = result.second_of_minute;
   assign rsp_chan.minute_of_hour   = result.minute_of_hour;
   assign rsp_chan.hour_of_day      = result.hour_of_day;
   assign rsp_chan.weekday_number   = result.weekday_number;
   assign rsp_chan.years_since_1900 = result.years_since_1900;
   assign rsp_chan.day_of_year      = result.day_of_year;
   assign rsp_chan.month_index      = result.month_index;
   assign rsp_chan.day_of_month     = result.day_of_month;

endmodule

FILE: tb/tb_epoch_seconds_to_utc_date.sv
module tb_epoch_seconds_to_utc_date;

   localparam int          RANDOM_ITEMS    = 1750;
   localparam int          DRAIN_CYCLES    = 300;
   localparam int          HOLD_OFF_CYCLES = 1500;
   localparam int          HOLD_OFF_AFTER  = 300;
   localparam int          PAUSE_AT_ITEM   = 900;
   localparam int          CYCLE_LIMIT     = 3000000;
   localparam longint      EPOCH_MAX       = 64'd4294967295;
   localparam int unsigned SECS_IN_DAY     = 86400;

   localparam int unsigned DAYS_BEFORE_MONTH [12] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
   };

   typedef struct {
      logic [31:0]            stamp;
      es2utc_pkg::result_type date;
   } pending_date_type;

   typedef struct {
      logic [31:0]            stamp;
      bit                     typed;
      es2utc_pkg::result_type date;
   } directed_row_type;

   // Dates are written as second, minute, hour, weekday, year - 1900,
   // day of year, month, day of month.
   localparam int N_DIRECTED = 24;
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{32'd0,          1'b1, '{6'd0, 6'd0, 5'd0, 3'd5, 8'd70, 9'd0, 4'd0, 5'd1}},
      '{32'd59,         1'b0, '0},
      '{32'd60,         1'b0, '0},
      '{32'd3599,       1'b0, '0},
      '{32'd3600,       1'b0, '0},
      '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 3'd5, 8'd70, 9'd0, 4'd0, 5'd1}},
      '{32'd86400,      1'b1, '{6'd0, 6'd0, 5'd0, 3'd6, 8'd70, 9'd1, 4'd0, 5'd2}},
      '{32'd68169599,   1'b0, '0},
      '{32'd68169600,   1'b0, '0},
      '{32'd68256000,   1'b0, '0},
      '{32'd94694399,   1'b0, '0},
      '{32'd946684799,  1'b0, '0},
      '{32'd951782400,  1'b0, '0},
      '{32'd951868800,  1'b0, '0},
      '{32'd978307199,  1'b0, '0},
      '{32'd2147483647, 1'b0, '0},
      '{32'd2147483648, 1'b0, '0},
      '{32'd4102444800, 1'b0, '0},
      '{32'd4107542399, 1'b0, '0},
      '{32'd4107542400, 1'b0, '0},
      '{32'd4291747199, 1'b0, '0},
      '{32'h55555555,   1'b0, '0},
      '{32'hAAAAAAAA,   1'b0, '0},
      '{32'hFFFFFFFF,   1'b1, '{6'd15, 6'd28, 5'd6, 3'd1, 8'd206, 9'd37, 4'd1, 5'd7}}
   };

   logic clock;
   logic reset;
   int   cycle_count;
   int   error_count;
   int   dates_checked;
   int   stamps_sent;
   bit   held_off;

   pending_date_type pending_dates [$];

   es2utc_req_if req_bus ();
   es2utc_rsp_if rsp_bus ();

   epoch_seconds_to_utc_date u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles with %0d dates outstanding",
                  $time, cycle_count, pending_dates.size());
         $display("[epoch_seconds_to_utc_date] ERROR");
         $finish;
      end
   end

   function automatic bit gregorian_leap(input int unsigned year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic int unsigned days_to_year(input int unsigned year);
      int unsigned total;
      total = 0;
      for (int unsigned y = 1970; y < year; y++)
         total += gregorian_leap(y) ? 366 : 365;
      return total;
   endfunction

   function automatic es2utc_pkg::result_type utc_date_of(input logic [31:0] stamp);
      int unsigned            sod;
      int unsigned            days;
      int unsigned            year;
      int unsigned            work;
      int unsigned            mon;
      int unsigned            mday;
      es2utc_pkg::result_type date;
      sod  = stamp % SECS_IN_DAY;
      days = stamp / SECS_IN_DAY;
      date.second_of_minute = 6'(sod % 60);
      date.minute_of_hour   = 6'((sod / 60) % 60);
      date.hour_of_day      = 5'(sod / 3600);
      date.weekday_number   = 3'((4 + days) % 7 + 1);
      year = 1970;
      while (days >= (gregorian_leap(year) ? 366 : 365)) begin
         days -= gregorian_leap(year) ? 366 : 365;
         year++;
      end
      date.years_since_1900 = 8'(year - 1900);
      date.day_of_year      = 9'(days);
      // In a leap year the 29th of February borrows the 28th's table slot,
      // and every later day moves back by one before the month search.
      work = days;
      mday = 1;
      if (gregorian_leap(year) && work > 58) begin
         if (work == 59)
            mday = 2;
         work--;
      end
      mon = 11;
      while (mon != 0 && DAYS_BEFORE_MONTH[mon] > work)
         mon--;
      mday += work - DAYS_BEFORE_MONTH[mon];
      date.month_index  = 4'(mon);
      date.day_of_month = 5'(mday);
      return date;
   endfunction

   // Most timestamps land near the edges that matter: day, month and year
   // changes, leap days (and the missing one in 2100), and the 32-bit limit.
   function automatic logic [31:0] pick_stamp();
      longint      secs;
      int unsigned year;
      int unsigned yday;
      secs = 0;
      case ($urandom_range(0, 9))
         0, 1, 2: secs = longint'($urandom);
         3, 4: begin
            year = $urandom_range(1971, 2106);
            secs = longint'(days_to_year(year)) * SECS_IN_DAY +
                   longint'($urandom_range(0, 4 * SECS_IN_DAY)) - 2 * SECS_IN_DAY;
         end
         5, 6: begin
            year = 1972 + 4 * $urandom_range(0, 33);
            yday = $urandom_range(57, 61);
            secs = longint'(days_to_year(year) + yday) * SECS_IN_DAY +
                   longint'($urandom_range(0, SECS_IN_DAY - 1));
         end
         7: begin
            year = $urandom_range(1970, 2105);
            yday = DAYS_BEFORE_MONTH[$urandom_range(1, 11)] + $urandom_range(0, 2) - 1;
            secs = longint'(days_to_year(year) + yday) * SECS_IN_DAY +
                   longint'($urandom_range(0, SECS_IN_DAY - 1));
         end
         8: secs = longint'($urandom_range(0, 400000));
         default: secs = EPOCH_MAX - longint'($urandom_range(0, 40 * SECS_IN_DAY));
      endcase
      if (secs < 0)
         secs = 0;
      if (secs > EPOCH_MAX)
         secs = EPOCH_MAX;
      return secs[31:0];
   endfunction

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 45)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   task automatic offer_stamp(input logic [31:0] stamp, input es2utc_pkg::result_type date,
                              input bit quiet);
      int               gap;
      pending_date_type entry;
      gap = pick_gap(quiet);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.epoch_seconds <= stamp;
      do @(posedge clock); while (!req_bus.ready);
      entry.stamp   = stamp;
      entry.date    = date;
      pending_dates = {pending_dates, entry};
      stamps_sent++;
   endtask

   task automatic wait_for_all_dates();
      req_bus.valid <= 1'b0;
      while (pending_dates.size() != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] stamp;
      req_bus.valid         <= 1'b0;
      req_bus.epoch_seconds <= '0;
      @(posedge clock);
      while (reset)
         @(posedge clock);

      foreach (directed_rows[i]) begin
         stamp = directed_rows[i].stamp;
         offer_stamp(stamp, directed_rows[i].typed ? directed_rows[i].date
                                                   : utc_date_of(stamp), 1'b0);
      end
      wait_for_all_dates();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         stamp = pick_stamp();
         // Every few hundred items a run of back-to-back transfers.
         offer_stamp(stamp, utc_date_of(stamp), (n % 300) < 40);
         if (n == PAUSE_AT_ITEM)
            wait_for_all_dates();
      end
      req_bus.valid <= 1'b0;

      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d timestamps (%0d directed: day, leap-day, century and 32-bit edges),",
               stamps_sent, N_DIRECTED);
      $display("checked %0d dates over %0d cycles, with one %0d-cycle output stall.",
               dates_checked, cycle_count, held_off ? HOLD_OFF_CYCLES : 0);
      if (error_count == 0)
         $display("[epoch_seconds_to_utc_date] OK");
      else
         $display("[epoch_seconds_to_utc_date] ERROR");
      $finish;
   end

   initial begin : receiver
      int burst;
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                              : $urandom_range(1, 20);
         gap   = pick_gap(1'b0);
         rsp_bus.ready <= 1'b1;
         repeat (burst) @(posedge clock);
         if (!held_off && dates_checked >= HOLD_OFF_AFTER) begin
            // Long stall so the block backs up and refuses new timestamps.
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic check_field(input logic [31:0] stamp, input string field,
                              input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: stamp %0d %s expected %0d, got %0d", $time, stamp, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      pending_date_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_dates.size() == 0) begin
            $display("%0t: result with no timestamp outstanding, expected none, got %0d-%0d-%0d",
                     $time, rsp_bus.years_since_1900, rsp_bus.month_index,
                     rsp_bus.day_of_month);
            error_count++;
         end else begin
            want = pending_dates.pop_front();
            check_field(want.stamp, "second_of_minute", want.date.second_of_minute,
                        rsp_bus.second_of_minute);
            check_field(want.stamp, "minute_of_hour", want.date.minute_of_hour,
                        rsp_bus.minute_of_hour);
            check_field(want.stamp, "hour_of_day", want.date.hour_of_day,
                        rsp_bus.hour_of_day);
            check_field(want.stamp, "weekday_number", want.date.weekday_number,
                        rsp_bus.weekday_number);
            check_field(want.stamp, "years_since_1900", want.date.years_since_1900,
                        rsp_bus.years_since_1900);
            check_field(want.stamp, "day_of_year", want.date.day_of_year,
                        rsp_bus.day_of_year);
            check_field(want.stamp, "month_index", want.date.month_index,
                        rsp_bus.month_index);
            check_field(want.stamp, "day_of_month", want.date.day_of_month,
                        rsp_bus.day_of_month);
            dates_checked++;
         end
      end
   end

endmodule

FILE: epoch_seconds_to_utc_date.f
hdl/es2utc_pkg.sv
hdl/es2utc_if.sv
hdl/es2utc_datapath.sv
hdl/es2utc_ctrl.sv
hdl/epoch_seconds_to_utc_date.sv
tb/tb_epoch_seconds_to_utc_date.sv
